/* rtl/mte_pkg.sv */
// package for the multi-mode text escaper
// holds mode codes, escape run constants and the per-byte escape function
// no dependencies
package mte_pkg;

    typedef enum logic [1:0] {
        MODE_HTML   = 2'd0,
        MODE_INPUT  = 2'd1,
        MODE_TAREA  = 2'd2,
        MODE_SCRIPT = 2'd3
    } t_mode;

    localparam int RUN_MAX = 6;
    localparam int RUN_W   = 8 * RUN_MAX;

    typedef logic [RUN_W-1:0] t_run_text;
    typedef logic [2:0]       t_run_len;

    // escaped run: first byte sits in the top byte lane
    typedef struct packed {
        t_run_text text;
        t_run_len  len;
        logic      trail_next;
    } t_run;

    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    localparam t_run_text RUN_AMP   = {"&#38;", 8'h00};
    localparam t_run_text RUN_SPACE = "&#160;";
    localparam t_run_text RUN_SQUOT = {"&#39;", 8'h00};
    localparam t_run_text RUN_SLASH = {"&#47;", 8'h00};
    localparam t_run_text RUN_LT    = {"&#60;", 8'h00};
    localparam t_run_text RUN_GT    = {"&#62;", 8'h00};
    localparam t_run_text RUN_DQUOT = {"&#34;", 8'h00};
    localparam t_run_text RUN_BSL   = {"&#92;", 8'h00};
    localparam t_run_text RUN_BR    = {"<BR>", 16'h0000};
    localparam t_run_text RUN_S_BSL = {"\\\\", 32'h0};
    localparam t_run_text RUN_S_DQ  = {"\\\"", 32'h0};
    localparam t_run_text RUN_S_SQ  = {"\\'", 32'h0};
    localparam t_run_text RUN_S_LF  = {"\\n", 32'h0};
    localparam t_run_text RUN_S_CR  = {"\\r", 32'h0};
    localparam t_run_text RUN_S_SOH = {"\\x01", 16'h0};

    function automatic t_run escape_run(input logic [7:0] b, input logic start,
                                        input t_mode mode, input logic trail);
        t_run r;
        r.text       = {b, {(RUN_W-8){1'b0}}};
        r.len        = 3'd1;
        r.trail_next = 1'b0;
        if (mode == MODE_SCRIPT) begin
            if (trail && !start) begin
                r.trail_next = 1'b0;
            end else if (b[7]) begin
                r.trail_next = 1'b1;
            end else begin
                case (b)
                    CH_BSL: begin
                        r.text = RUN_S_BSL;
                        r.len  = 3'd2;
                    end
                    CH_DQUOT: begin
                        r.text = RUN_S_DQ;
                        r.len  = 3'd2;
                    end
                    CH_SQUOT: begin
                        r.text = RUN_S_SQ;
                        r.len  = 3'd2;
                    end
                    CH_LF: begin
                        r.text = RUN_S_LF;
                        r.len  = 3'd2;
                    end
                    CH_CR: begin
                        r.text = RUN_S_CR;
                        r.len  = 3'd2;
                    end
                    CH_SOH: begin
                        r.text = RUN_S_SOH;
                        r.len  = 3'd4;
                    end
                    default: begin
                        r.len = 3'd1;
                    end
                endcase
            end
        end else begin
            case (b)
                CH_AMP: begin
                    r.text = RUN_AMP;
                    r.len  = 3'd5;
                end
                CH_SQUOT: begin
                    r.text = RUN_SQUOT;
                    r.len  = 3'd5;
                end
                CH_SLASH: begin
                    r.text = RUN_SLASH;
                    r.len  = 3'd5;
                end
                CH_LT: begin
                    r.text = RUN_LT;
                    r.len  = 3'd5;
                end
                CH_GT: begin
                    r.text = RUN_GT;
                    r.len  = 3'd5;
                end
                CH_DQUOT: begin
                    r.text = RUN_DQUOT;
                    r.len  = 3'd5;
                end
                CH_BSL: begin
                    r.text = RUN_BSL;
                    r.len  = 3'd5;
                end
                CH_SPACE: begin
                    if (mode == MODE_HTML) begin
                        r.text = RUN_SPACE;
                        r.len  = 3'd6;
                    end
                end
                CH_LF, CH_CR: begin
                    if (mode == MODE_HTML) begin
                        r.text = RUN_BR;
                        r.len  = 3'd4;
                    end else if (mode == MODE_INPUT) begin
                        r.len = 3'd0;
                    end
                end
                default: begin
                    r.len = 3'd1;
                end
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/mte_if.sv */
// stream interfaces for the multi-mode text escaper
// input carries text bytes, output carries escaped bytes; no dependencies
interface mte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_start;

    modport source (output valid, output text_byte, output string_start, input ready);
    modport sink   (input valid, input text_byte, input string_start, output ready);
endinterface

interface mte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* rtl/multi_mode_text_escaper.sv */
// multi-mode text escaper top level
// depends on mte_pkg and the mte_in_if / mte_out_if interfaces
//
// Each accepted text byte is looked up combinationally and its escaped run (zero to six
// bytes) is loaded into a run shift register, which feeds an output register one byte
// per cycle while o_out.ready does not stall it. A plain byte stream flows at one
// transaction per cycle under the same condition; an escaped byte holds off further input
// until the single run shift register passes out its last byte. Newline and carriage
// return in form input mode produce no output transaction. The mode register is written
// through i_cfg_we / i_cfg_wdata and must only change while the block is idle.
module multi_mode_text_escaper_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    mte_in_if.sink            i_in,
    mte_out_if.source         o_out
);

    mte_pkg::t_mode     r_mode;
    logic               r_trail;
    mte_pkg::t_run_text r_run_text;
    mte_pkg::t_run_len  r_run_left;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    mte_pkg::t_run      n_run;
    logic               out_load;
    logic               run_move;
    logic               run_pop_last;
    logic               in_acc;

    assign out_load     = !r_out_valid || o_out.ready;
    assign run_move     = (r_run_left != 3'd0) && out_load;
    assign run_pop_last = run_move && (r_run_left == 3'd1);
    assign i_in.ready   = (r_run_left == 3'd0) || run_pop_last;
    assign in_acc       = i_in.valid && i_in.ready;

    always_comb begin
        n_run = mte_pkg::escape_run(i_in.text_byte, i_in.string_start, r_mode, r_trail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mte_pkg::MODE_HTML;
        end else if (i_cfg_we) begin
            r_mode <= mte_pkg::t_mode'(i_cfg_wdata);
        end
    end

    // run shift register: next byte always in the top lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail    <= 1'b0;
            r_run_left <= 3'd0;
        end else begin
            if (in_acc) begin
                r_trail    <= n_run.trail_next;
                r_run_left <= n_run.len;
            end else if (run_move) begin
                r_run_left <= r_run_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_run_text <= n_run.text;
        end else if (run_move) begin
            r_run_text <= {r_run_text[mte_pkg::RUN_W-9:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= run_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_move) begin
            r_out_byte <= r_run_text[mte_pkg::RUN_W-1 -: 8];
            r_out_last <= (r_run_left == 3'd1);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

endmodule

/* test/multi_mode_text_escaper_core_tb.sv */
// testbench for multi_mode_text_escaper_core: drives text bytes in all four modes
// and checks every escaped output byte against an in-bench predictor
// depends on mte_pkg, mte_in_if / mte_out_if and the core itself
module multi_mode_text_escaper_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int MODE_SETTLE  = 10;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_esc_byte;

    localparam logic [7:0] SPECIAL_BYTES [12] = '{
        mte_pkg::CH_AMP, mte_pkg::CH_SQUOT, mte_pkg::CH_SLASH, mte_pkg::CH_LT,
        mte_pkg::CH_GT, mte_pkg::CH_DQUOT, mte_pkg::CH_BSL, mte_pkg::CH_SPACE,
        mte_pkg::CH_LF, mte_pkg::CH_CR, mte_pkg::CH_SOH, 8'h00
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    mte_in_if  in_ch ();
    mte_out_if out_ch ();

    multi_mode_text_escaper_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_esc_byte      pending_bytes [$];
    mte_pkg::t_mode cur_mode;
    logic           trail_flag;
    int             mismatch_count;
    bit             sender_gaps;
    bit             sink_stalls;
    int             long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_byte(input logic [7:0] b, input logic last);
        t_esc_byte e;
        e.out_byte = b;
        e.run_last = last;
        pending_bytes.push_back(e);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(8'(s[i]), i == s.len() - 1);
        end
    endfunction

    function automatic void predict_escape(input logic [7:0] b, input logic first);
        if (cur_mode == mte_pkg::MODE_SCRIPT) begin
            if (first) trail_flag = 1'b0;
            if (trail_flag) begin
                // second byte of a double-byte character goes through as is
                trail_flag = 1'b0;
                push_byte(b, 1'b1);
            end else if (b[7]) begin
                trail_flag = 1'b1;
                push_byte(b, 1'b1);
            end else begin
                case (b)
                    mte_pkg::CH_BSL:   push_text("\\\\");
                    mte_pkg::CH_DQUOT: push_text("\\\"");
                    mte_pkg::CH_SQUOT: push_text("\\'");
                    mte_pkg::CH_LF:    push_text("\\n");
                    mte_pkg::CH_CR:    push_text("\\r");
                    mte_pkg::CH_SOH:   push_text("\\x01");
                    default:           push_byte(b, 1'b1);
                endcase
            end
        end else begin
            trail_flag = 1'b0;
            case (b)
                mte_pkg::CH_AMP:   push_text("&#38;");
                mte_pkg::CH_SQUOT: push_text("&#39;");
                mte_pkg::CH_SLASH: push_text("&#47;");
                mte_pkg::CH_LT:    push_text("&#60;");
                mte_pkg::CH_GT:    push_text("&#62;");
                mte_pkg::CH_DQUOT: push_text("&#34;");
                mte_pkg::CH_BSL:   push_text("&#92;");
                mte_pkg::CH_SPACE: begin
                    if (cur_mode == mte_pkg::MODE_HTML) push_text("&#160;");
                    else push_byte(b, 1'b1);
                end
                mte_pkg::CH_LF, mte_pkg::CH_CR: begin
                    // form input drops line breaks entirely
                    if (cur_mode == mte_pkg::MODE_HTML) push_text("<BR>");
                    else if (cur_mode != mte_pkg::MODE_INPUT) push_byte(b, 1'b1);
                end
                default:  push_byte(b, 1'b1);
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return SPECIAL_BYTES[$urandom_range(0, 11)];
        if (r < 60) return 8'($urandom_range(128, 255));
        if (r < 85) return 8'($urandom_range(33, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.text_byte    <= b;
        in_ch.string_start <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_escape(b, first);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_mode(input mte_pkg::t_mode m);
        wait_drained();
        // a dropped line break may still be in flight with nothing expected
        repeat (MODE_SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode = m;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_html_entities();
        // relies on the reset value of the mode register
        foreach (SPECIAL_BYTES[i]) begin
            if (SPECIAL_BYTES[i] != mte_pkg::CH_SOH) send_byte(SPECIAL_BYTES[i], i == 0);
        end
        send_byte(8'hff, 1'b0);
        send_byte(mte_pkg::CH_SOH, 1'b0);
    endtask

    task automatic test_input_and_textarea();
        set_mode(mte_pkg::MODE_INPUT);
        send_byte(mte_pkg::CH_SPACE, 1'b1);
        send_byte(mte_pkg::CH_LF, 1'b0);
        send_byte(mte_pkg::CH_CR, 1'b0);
        send_byte(mte_pkg::CH_LT, 1'b0);
        set_mode(mte_pkg::MODE_TAREA);
        send_byte(mte_pkg::CH_SPACE, 1'b1);
        send_byte(mte_pkg::CH_LF, 1'b0);
        send_byte(mte_pkg::CH_CR, 1'b0);
    endtask

    task automatic test_script_escapes();
        set_mode(mte_pkg::MODE_SCRIPT);
        send_byte(mte_pkg::CH_BSL, 1'b1);
        send_byte(mte_pkg::CH_DQUOT, 1'b0);
        send_byte(mte_pkg::CH_SQUOT, 1'b0);
        send_byte(mte_pkg::CH_LF, 1'b0);
        send_byte(mte_pkg::CH_CR, 1'b0);
        send_byte(mte_pkg::CH_SOH, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(mte_pkg::CH_BSL, 1'b0);
        // lead byte ending a string, next string start drops the pending trail
        send_byte(8'hff, 1'b0);
        send_byte(mte_pkg::CH_SQUOT, 1'b1);
    endtask

    task automatic test_random_strings(input mte_pkg::t_mode m, input int n_items);
        int sent;
        int len;
        set_mode(m);
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                send_byte(pick_text_byte(), k == 0 || $urandom_range(0, 19) == 0);
            end
            sent += len;
        end
    endtask

    task automatic test_output_backpressure();
        set_mode(mte_pkg::MODE_HTML);
        sender_gaps   = 1'b0;
        long_hold_req = LONG_HOLD;
        for (int k = 0; k < 30; k++) begin
            send_byte(SPECIAL_BYTES[$urandom_range(0, 7)], k == 0);
        end
        sender_gaps = 1'b1;
    endtask

    // ---------------------------------------------------------------- sink side

    initial begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req > 0) begin
                out_ch.ready  <= 1'b0;
                hold_left     = long_hold_req - 1;
                long_hold_req = 0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                hold_left    = pick_gap();
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_esc_byte exp_b;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected output transaction: out_byte %h run_last %b",
                       out_ch.out_byte, out_ch.run_last);
                mismatch_count++;
            end else begin
                exp_b = pending_bytes.pop_front();
                if (out_ch.out_byte !== exp_b.out_byte) begin
                    $error("out_byte: expected %h, actual %h", exp_b.out_byte,
                           out_ch.out_byte);
                    mismatch_count++;
                end
                if (out_ch.run_last !== exp_b.run_last) begin
                    $error("run_last: expected %b, actual %b", exp_b.run_last,
                           out_ch.run_last);
                    mismatch_count++;
                end
            end
        end
    end

    // ends the run when neither side moves for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
            else idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        mte_pkg::t_mode phase_modes [8];
        phase_modes = '{mte_pkg::MODE_SCRIPT, mte_pkg::MODE_HTML, mte_pkg::MODE_INPUT,
                        mte_pkg::MODE_TAREA, mte_pkg::MODE_SCRIPT,
                        mte_pkg::t_mode'($urandom_range(0, 3)),
                        mte_pkg::t_mode'($urandom_range(0, 3)),
                        mte_pkg::MODE_HTML};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.text_byte    = '0;
        in_ch.string_start = 1'b0;
        cur_mode           = mte_pkg::MODE_HTML;
        trail_flag         = 1'b0;
        mismatch_count     = 0;
        sender_gaps        = 1'b1;
        sink_stalls        = 1'b1;
        long_hold_req      = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_html_entities();
        test_input_and_textarea();
        test_script_escapes();
        foreach (phase_modes[p]) begin
            // one phase runs with no idling on either side
            sender_gaps = (p != 2);
            sink_stalls = (p != 2);
            test_random_strings(phase_modes[p], 41);
        end
        sink_stalls = 1'b1;
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
